// ===== hw/rtl/sc2a_pkg.sv =====
// Shared types, scancodes and key maps for the scancode to ASCII decoder.
package sc2a_pkg;

    localparam logic [7:0] LINE_LIMIT = 8'd127;

    typedef logic [7:0] t_code;
    typedef logic [7:0] t_fill;
    typedef logic [6:0] t_char;
    typedef logic [1:0] t_term;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_CHAR   = 3'd1,
        ACT_BKSP   = 3'd2,
        ACT_ENTER  = 3'd3,
        ACT_TAB    = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_SWITCH = 3'd6
    } t_action;

    typedef struct packed {
        t_action action;
        t_char   character;
        t_term   target_terminal;
    } t_result;

    localparam t_code SC_CTRL_DN  = 8'h1D;
    localparam t_code SC_CTRL_UP  = 8'h9D;
    localparam t_code SC_SHIFT_DN = 8'h2A;
    localparam t_code SC_SHIFT_UP = 8'hAA;
    localparam t_code SC_ALT_DN   = 8'h38;
    localparam t_code SC_ALT_UP   = 8'hB8;
    localparam t_code SC_CAPS_DN  = 8'h3A;
    localparam t_code SC_BKSP     = 8'h0E;
    localparam t_code SC_ENTER    = 8'h1C;
    localparam t_code SC_TAB      = 8'h0F;
    localparam t_code SC_L_KEY    = 8'd38;
    localparam t_code SC_F1       = 8'd59;
    localparam t_code SC_F3       = 8'd61;
    localparam t_code MAP_SIZE    = 8'd58;

    localparam t_char CH_LOWER_A = 7'h61;
    localparam t_char CH_LOWER_Z = 7'h7A;

    // Maps padded to 64 entries so a 6-bit index is always in range.
    localparam t_char PLAIN_MAP [64] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam t_char SHIFTED_MAP [64] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

// ===== hw/rtl/sc2a_decode.sv =====
// Modifier flags and combinational scancode decode.
module sc2a_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  sc2a_pkg::t_code   i_scancode,
    input  sc2a_pkg::t_fill   i_buffer_fill,
    input  logic              i_switch_busy,
    output sc2a_pkg::t_result o_result
);
    import sc2a_pkg::*;

    logic    r_ctrl, r_shift, r_caps, r_alt;
    logic    n_ctrl, n_shift, n_caps, n_alt;
    logic    full;
    logic    in_map;
    logic    is_fkey;
    logic    is_letter;
    t_char   plain_ch;
    t_char   shifted_ch;
    t_char   ch;
    t_code   term_off;
    t_result res;

    assign full      = (i_buffer_fill == LINE_LIMIT);
    assign in_map    = (i_scancode != '0) && (i_scancode < MAP_SIZE);
    assign is_fkey   = (i_scancode >= SC_F1) && (i_scancode <= SC_F3);
    assign plain_ch   = PLAIN_MAP[i_scancode[5:0]];
    assign shifted_ch = SHIFTED_MAP[i_scancode[5:0]];
    assign is_letter = (plain_ch >= CH_LOWER_A) && (plain_ch <= CH_LOWER_Z);
    assign term_off  = i_scancode - SC_F1;

    // caps only lifts letters, and only with shift up; caps+shift is plain
    always_comb begin
        if (r_caps) begin
            ch = (is_letter && !r_shift) ? shifted_ch : plain_ch;
        end else begin
            ch = r_shift ? shifted_ch : plain_ch;
        end
    end

    always_comb begin
        n_ctrl  = r_ctrl;
        n_shift = r_shift;
        n_caps  = r_caps;
        n_alt   = r_alt;
        res     = '{action: ACT_NONE, character: '0, target_terminal: '0};
        if (!i_switch_busy) begin
            case (i_scancode)
                SC_CTRL_DN:  n_ctrl  = 1'b1;
                SC_CTRL_UP:  n_ctrl  = 1'b0;
                SC_SHIFT_DN: n_shift = 1'b1;
                SC_SHIFT_UP: n_shift = 1'b0;
                SC_ALT_DN:   n_alt   = 1'b1;
                SC_ALT_UP:   n_alt   = 1'b0;
                SC_CAPS_DN:  n_caps  = !r_caps;
                SC_BKSP: begin
                    if (i_buffer_fill != '0) res.action = ACT_BKSP;
                end
                SC_ENTER: res.action = ACT_ENTER;
                SC_TAB: begin
                    if (!full) res.action = ACT_TAB;
                end
                default: begin
                    if (!full) begin
                        if (in_map) begin
                            if (r_ctrl) begin
                                if (i_scancode == SC_L_KEY) res.action = ACT_CLEAR;
                            end else if (ch != '0) begin
                                res.action    = ACT_CHAR;
                                res.character = ch;
                            end
                        end else if (is_fkey && r_alt) begin
                            res.action          = ACT_SWITCH;
                            res.target_terminal = term_off[1:0];
                        end
                    end
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= 1'b0;
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_alt   <= 1'b0;
        end else if (i_fire) begin
            r_ctrl  <= n_ctrl;
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_alt   <= n_alt;
        end
    end

    // flags move only when a word is decoded
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_ctrl) && $stable(r_shift) && $stable(r_caps) && $stable(r_alt))
        else $error("modifier flags changed without a decoded word");
    a_busy_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_switch_busy |=> $stable(r_caps) && $stable(r_ctrl)
                                    && $stable(r_shift) && $stable(r_alt))
        else $error("busy word changed modifier flags");
    a_busy_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_switch_busy |-> o_result.action == ACT_NONE)
        else $error("busy word produced an action");

endmodule

// ===== hw/rtl/scancode_to_ascii_decoder_top.sv =====
// Top level: input register, decoder and result register of the scancode decoder.
// Usage:
//   Input channel (i_valid / o_ready) carries one word: a set-1 scancode, the
//   current line-buffer fill and a busy flag. Output channel (o_valid / i_ready)
//   carries one result word per input word: action, character, target terminal.
//   The word is captured in an input register, decoded by short logic that
//   also updates the ctrl/shift/alt/caps flags, and lands in a result register.
//   Each word passes through the input register and then the result register,
//   whose valid bit drives o_valid.
//   Throughput: one word per cycle while the receiver keeps up; o_ready stays high while the result
//   register drains or is empty, so words follow back to back.
//   When the receiver stalls, the result register holds, then the input
//   register fills and o_ready drops; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties both registers and clears all
//   modifier flags, caps lock included.
module scancode_to_ascii_decoder_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sc2a_pkg::t_code i_scancode,
    input  sc2a_pkg::t_fill i_buffer_fill,
    input  logic            i_switch_busy,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_action,
    output sc2a_pkg::t_char o_character,
    output sc2a_pkg::t_term o_target_terminal
);
    import sc2a_pkg::*;

    logic    r_in_valid;
    t_code   r_scancode;
    t_fill   r_fill;
    logic    r_busy;
    logic    r_out_valid;
    t_result r_result;
    t_result dec_result;
    logic    adv;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_scancode <= i_scancode;
            r_fill     <= i_buffer_fill;
            r_busy     <= i_switch_busy;
        end
        if (adv) r_result <= dec_result;
    end

    sc2a_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (adv),
        .i_scancode    (r_scancode),
        .i_buffer_fill (r_fill),
        .i_switch_busy (r_busy),
        .o_result      (dec_result)
    );

    assign o_valid           = r_out_valid;
    assign o_action          = r_result.action;
    assign o_character       = r_result.character;
    assign o_target_terminal = r_result.target_terminal;

    // a held word in the input register is never dropped
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("input word lost while stalled");
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_result.action == ACT_CHAR) || (o_character == '0))
        else $error("character set on a non-character action");
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_result.action != ACT_SWITCH) |-> o_target_terminal == '0)
        else $error("terminal set on a non-switch action");
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_result.action == ACT_SWITCH) |-> o_target_terminal != 2'd3)
        else $error("terminal index out of range");

endmodule

// ===== dv/scancode_to_ascii_decoder_top_test.sv =====
// Testbench for the scancode to ASCII decoder: directed table, random key streams, handshake stress.
module scancode_to_ascii_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sc2a_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 3000;
    localparam int SETTLE_CYCLES    = 8;

    // scancodes the package does not name
    localparam t_code KEY_NULL   = 8'd0;
    localparam t_code KEY_1      = 8'd2;
    localparam t_code KEY_Q      = 8'd16;
    localparam t_code KEY_A      = 8'd30;
    localparam t_code KEY_RSHIFT = 8'd54;
    localparam t_code KEY_F2     = 8'd60;
    localparam t_code KEY_F4     = 8'd62;
    localparam t_code KEY_TOP    = 8'd255;
    localparam t_code RELEASE    = 8'h80;

    localparam t_fill FILL_EMPTY = 8'd0;
    localparam t_fill FILL_MID   = 8'd5;
    localparam t_fill FILL_NEAR  = 8'd126;
    localparam t_fill FILL_MAX   = 8'd128;

    localparam t_char CH_A_LOW   = 7'h61;
    localparam t_char CH_NONE    = 7'h00;
    localparam t_term TERM_NONE  = 2'd0;

    localparam t_char KEYS_PLAIN [58] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam t_char KEYS_SHIFT [58] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    typedef struct {
        logic    typed;
        t_result want;
    } t_offer_note;

    typedef struct {
        t_code   code;
        t_fill   fill;
        logic    busy;
        logic    typed;
        t_result want;
    } t_key_row;

    logic  i_clk         = 1'b0;
    logic  i_rst_n       = 1'b0;
    logic  i_valid       = 1'b0;
    t_code i_scancode    = '0;
    t_fill i_buffer_fill = '0;
    logic  i_switch_busy = 1'b0;
    logic  i_ready       = 1'b0;
    logic  o_ready;
    logic  o_valid;
    logic [2:0] o_action;
    t_char o_character;
    t_term o_target_terminal;

    // predictor state
    logic ctrl_down  = 1'b0;
    logic shift_down = 1'b0;
    logic caps_lock  = 1'b0;
    logic alt_down   = 1'b0;

    t_result     expected_results [$];
    t_offer_note offer_notes [$];
    t_key_row    directed_rows [$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int stall_cycles   = 0;
    int send_idle_pct  = 18;
    int recv_idle_pct  = 78;
    logic hold_go      = 1'b0;

    scancode_to_ascii_decoder_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_scancode        (i_scancode),
        .i_buffer_fill     (i_buffer_fill),
        .i_switch_busy     (i_switch_busy),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_action          (o_action),
        .o_character       (o_character),
        .o_target_terminal (o_target_terminal)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_result decode_key(input t_code code, input t_fill fill,
                                           input logic busy);
        t_result r;
        logic    full;
        t_char   ch;
        r.action          = ACT_NONE;
        r.character       = CH_NONE;
        r.target_terminal = TERM_NONE;
        full = (fill == LINE_LIMIT);
        if (busy)
            return r;
        case (code)
            SC_CTRL_DN:  ctrl_down = 1'b1;
            SC_CTRL_UP:  ctrl_down = 1'b0;
            SC_SHIFT_DN: shift_down = 1'b1;
            SC_SHIFT_UP: shift_down = 1'b0;
            SC_ALT_DN:   alt_down = 1'b1;
            SC_ALT_UP:   alt_down = 1'b0;
            SC_CAPS_DN:  caps_lock = ~caps_lock;
            SC_BKSP:     if (fill != FILL_EMPTY) r.action = ACT_BKSP;
            SC_ENTER:    r.action = ACT_ENTER;
            SC_TAB:      if (!full) r.action = ACT_TAB;
            default: begin
                if (full) begin
                    // full line swallows everything else, ctrl+l and alt+F too
                end else if (code >= 8'd1 && code < MAP_SIZE) begin
                    if (ctrl_down) begin
                        if (code == SC_L_KEY)
                            r.action = ACT_CLEAR;
                    end else begin
                        ch = KEYS_PLAIN[code[5:0]];
                        // caps only lifts letters, and shift cancels it
                        if (caps_lock) begin
                            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z && !shift_down)
                                ch = KEYS_SHIFT[code[5:0]];
                        end else if (shift_down) begin
                            ch = KEYS_SHIFT[code[5:0]];
                        end
                        if (ch != CH_NONE) begin
                            r.action    = ACT_CHAR;
                            r.character = ch;
                        end
                    end
                end else if (code >= SC_F1 && code <= SC_F3) begin
                    if (alt_down) begin
                        r.action          = ACT_SWITCH;
                        r.target_terminal = t_term'(code - SC_F1);
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] mismatch on result %0d, %s: got %0d, want %0d",
                 $realtime, results_seen, what, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic add_row(input t_code code, input t_fill fill, input logic busy,
                           input logic typed, input t_action act, input t_char ch,
                           input t_term term);
        t_key_row row;
        row.code                 = code;
        row.fill                 = fill;
        row.busy                 = busy;
        row.typed                = typed;
        row.want.action          = act;
        row.want.character       = ch;
        row.want.target_terminal = term;
        directed_rows.push_back(row);
    endtask

    // Called right after an accept edge (or after a drain), so valid gets one NBA per step.
    task automatic offer_word(input t_code code, input t_fill fill, input logic busy,
                              input logic typed, input t_result want);
        t_offer_note note;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        note.typed = typed;
        note.want  = want;
        offer_notes.push_back(note);
        i_valid       <= 1'b1;
        i_scancode    <= code;
        i_buffer_fill <= fill;
        i_switch_busy <= busy;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly plausible typing: modifiers, mapped keys, F keys, edit keys; some raw noise.
    task automatic pick_key(output t_code code, output t_fill fill, output logic busy);
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            case ($urandom_range(9))
                0:       code = SC_CTRL_DN;
                1, 2:    code = SC_CTRL_UP;
                3:       code = SC_SHIFT_DN;
                4:       code = SC_SHIFT_UP;
                5:       code = SC_ALT_DN;
                6:       code = SC_ALT_UP;
                7:       code = SC_CAPS_DN;
                8:       code = KEY_RSHIFT;
                default: code = RELEASE | t_code'($urandom_range(127));
            endcase
        end else if (sel < 65) begin
            code = t_code'($urandom_range(1, 57));
        end else if (sel < 75) begin
            code = t_code'($urandom_range(58, 62));
        end else if (sel < 85) begin
            case ($urandom_range(2))
                0:       code = SC_BKSP;
                1:       code = SC_ENTER;
                default: code = SC_TAB;
            endcase
        end else begin
            code = t_code'($urandom_range(255));
        end
        sel = $urandom_range(99);
        if (sel < 8)
            fill = LINE_LIMIT;
        else if (sel < 13)
            fill = FILL_EMPTY;
        else if (sel < 17)
            fill = FILL_MAX;
        else
            fill = t_fill'($urandom_range(128));
        busy = ($urandom_range(99) < 5);
    endtask

    // checks result words, predicts input words
    always @(posedge i_clk) begin : watch_ports
        t_result     exp_r;
        t_offer_note note;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word, action", o_action, ACT_NONE);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_action !== exp_r.action)
                        report_mismatch("action", o_action, exp_r.action);
                    if (o_character !== exp_r.character)
                        report_mismatch("character", o_character, exp_r.character);
                    if (o_target_terminal !== exp_r.target_terminal)
                        report_mismatch("target_terminal", o_target_terminal,
                                        exp_r.target_terminal);
                end
                results_seen++;
            end
            if (i_valid && o_ready) begin
                note  = offer_notes.pop_front();
                exp_r = decode_key(i_scancode, i_buffer_fill, i_switch_busy);
                if (note.typed)
                    exp_r = note.want;
                expected_results.push_back(exp_r);
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        static logic hold_taken = 1'b0;
        static int   hold_left  = 0;
        if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n && !(i_valid && o_ready) && !(o_valid && i_ready)) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("scancode_to_ascii_decoder_top_test: errors");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    initial begin : run_test
        t_code   code;
        t_fill   fill;
        logic    busy;
        t_result blank;
        blank.action          = ACT_NONE;
        blank.character       = CH_NONE;
        blank.target_terminal = TERM_NONE;

        add_row(KEY_A,       FILL_EMPTY, 1'b0, 1'b1, ACT_CHAR,  CH_A_LOW, TERM_NONE);
        add_row(KEY_TOP,     FILL_MAX,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_NULL,    FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        // busy word must not latch ctrl
        add_row(SC_CTRL_DN,  FILL_MID,   1'b1, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_BKSP,     FILL_EMPTY, 1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_BKSP,     FILL_MAX,   1'b0, 1'b1, ACT_BKSP,  CH_NONE, TERM_NONE);
        add_row(SC_ENTER,    LINE_LIMIT, 1'b0, 1'b1, ACT_ENTER, CH_NONE, TERM_NONE);
        add_row(SC_TAB,      LINE_LIMIT, 1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_TAB,      FILL_NEAR,  1'b0, 1'b1, ACT_TAB,   CH_NONE, TERM_NONE);
        add_row(KEY_Q,       LINE_LIMIT, 1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_RSHIFT,  FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_SHIFT_DN, FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_1,       FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_CAPS_DN,  FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_A,       FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_SHIFT_UP, FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_A,       FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_1,       FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_CAPS_DN,  FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_CTRL_DN,  FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_L_KEY,    FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_L_KEY,    LINE_LIMIT, 1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_CTRL_UP,  FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_ALT_DN,   FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_F1,       FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_F3,       LINE_LIMIT, 1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_F3,       FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_F4,      FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(SC_ALT_UP,   FILL_MID,   1'b0, 1'b1, ACT_NONE,  CH_NONE, TERM_NONE);
        add_row(KEY_F2,      FILL_MID,   1'b0, 1'b0, ACT_NONE,  CH_NONE, TERM_NONE);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            offer_word(directed_rows[k].code, directed_rows[k].fill, directed_rows[k].busy,
                       directed_rows[k].typed, directed_rows[k].want);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct <= 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct <= 18;
                end
                default: begin
                    // no idling; receiver still backs off once to fill the pipe
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                    hold_go <= 1'b1;
                end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                pick_key(code, fill, busy);
                offer_word(code, fill, busy, 1'b0, blank);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("scancode_to_ascii_decoder_top_test: clean");
        else
            $display("scancode_to_ascii_decoder_top_test: errors");
        $finish;
    end

endmodule
